// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the contour overlap run RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Fires when cond holds at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: forbidden condition seen");

// Fires when pre holds at one edge and post does not hold at the next.
`define ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: expected follow-up missing");

`endif

// ===== hdl/tcor_pkg.sv =====
// Package with the types and constants of the contour overlap run block.
`timescale 1ns / 1ps

package tcor_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_PERP_LIMIT_SQ = 2'd0;
   localparam logic [1:0] CSR_NORMAL_LIMIT  = 2'd1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 34;

   localparam int FRAME_LIMIT_DEFAULT = 4096;

   // Queue between the classifier and the run tracker.
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [QUEUE_PTR_W-1:0] tcor_ptr_type;
   typedef logic [QUEUE_CNT_W-1:0] tcor_count_type;

   localparam tcor_count_type QUEUE_FULL_COUNT = QUEUE_CNT_W'(QUEUE_DEPTH);
   localparam tcor_ptr_type   QUEUE_LAST_PTR   = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

   // One input word as the front end receives it.
   typedef struct packed {
      logic signed [15:0] contour_x;
      logic signed [15:0] contour_y;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] track_x;
      logic signed [15:0] track_y;
      logic        [11:0] frame_index;
      logic               last;
   } tcor_item_type;

   // Match thresholds from the configuration registers.
   typedef struct packed {
      logic [33:0] perp_limit_sq;
      logic [15:0] normal_limit;
   } tcor_limits_type;

   // Classified frame handed from the front end to the back end.
   typedef struct packed {
      logic        match;
      logic [11:0] frame;
      logic        last;
   } tcor_word_type;

endpackage

// ===== hdl/tcor_front.sv =====
// Front end: pipelined distance math that classifies each frame as a match.
`timescale 1ns / 1ps

module tcor_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  tcor_pkg::tcor_item_type  in_item,
   input  tcor_pkg::tcor_limits_type limits,
   output logic                     out_valid,
   output tcor_pkg::tcor_word_type  out_word
);

   // Stage 1: differences.
   logic               s1_valid_ff, s1_valid_in;
   logic signed [16:0] s1_dx_ff, s1_dx_in;
   logic signed [16:0] s1_dy_ff, s1_dy_in;
   logic signed [15:0] s1_nx_ff, s1_ny_ff;
   logic        [11:0] s1_frame_ff;
   logic               s1_last_ff;

   // Stage 2: products.
   logic               s2_valid_ff;
   logic signed [32:0] s2_pxn_ff, s2_pxn_in;
   logic signed [32:0] s2_pyn_ff, s2_pyn_in;
   logic        [31:0] s2_sxx_ff, s2_sxx_in;
   logic        [31:0] s2_syy_ff, s2_syy_in;
   logic        [11:0] s2_frame_ff;
   logic               s2_last_ff;
   logic signed [33:0] dx_wide, dy_wide, sxx_full, syy_full;

   // Stage 3: projection on the normal and squared length.
   logic               s3_valid_ff;
   logic signed [33:0] s3_dn_ff, s3_dn_in;
   logic        [32:0] s3_sq_ff, s3_sq_in;
   logic        [11:0] s3_frame_ff;
   logic               s3_last_ff;

   // Stage 4: magnitude of the projection.
   logic               s4_valid_ff;
   logic        [31:0] s4_adn_ff, s4_adn_in;
   logic        [32:0] s4_sq_ff;
   logic        [11:0] s4_frame_ff;
   logic               s4_last_ff;
   logic        [33:0] dn_neg;

   // Stage 5: squared projection and the along-normal test.
   logic               s5_valid_ff;
   logic        [63:0] s5_dsq_ff, s5_dsq_in;
   logic               s5_nok_ff, s5_nok_in;
   logic        [32:0] s5_sq_ff;
   logic        [11:0] s5_frame_ff;
   logic               s5_last_ff;

   logic        [36:0] perp_rhs;
   logic               perp_ok;

   assign s1_valid_in = in_valid;
   assign s1_dx_in = {in_item.contour_x[15], in_item.contour_x}
                   - {in_item.track_x[15], in_item.track_x};
   assign s1_dy_in = {in_item.contour_y[15], in_item.contour_y}
                   - {in_item.track_y[15], in_item.track_y};

   assign s2_pxn_in = $signed({{16{s1_dx_ff[16]}}, s1_dx_ff})
                    * $signed({{17{s1_nx_ff[15]}}, s1_nx_ff});
   assign s2_pyn_in = $signed({{16{s1_dy_ff[16]}}, s1_dy_ff})
                    * $signed({{17{s1_ny_ff[15]}}, s1_ny_ff});
   assign dx_wide   = $signed({{17{s1_dx_ff[16]}}, s1_dx_ff});
   assign dy_wide   = $signed({{17{s1_dy_ff[16]}}, s1_dy_ff});
   assign sxx_full  = dx_wide * dx_wide;
   assign syy_full  = dy_wide * dy_wide;
   assign s2_sxx_in = sxx_full[31:0];
   assign s2_syy_in = syy_full[31:0];

   assign s3_dn_in = {s2_pxn_ff[32], s2_pxn_ff} + {s2_pyn_ff[32], s2_pyn_ff};
   assign s3_sq_in = {1'b0, s2_sxx_ff} + {1'b0, s2_syy_ff};

   // The projection stays below 2^32 in magnitude, so 32 bits hold it.
   assign dn_neg    = ~s3_dn_ff + 34'd1;
   assign s4_adn_in = s3_dn_ff[33] ? dn_neg[31:0] : s3_dn_ff[31:0];

   assign s5_dsq_in = {32'd0, s4_adn_ff} * {32'd0, s4_adn_ff};
   assign s5_nok_in = s4_adn_ff <= {2'b00, limits.normal_limit, 14'd0};

   // The squared projection carries a scale of 2^28, so the perpendicular test
   // reduces to comparing the squared length against the top bits of the squared
   // projection plus the limit.
   assign perp_rhs = {1'b0, s5_dsq_ff[63:28]} + {3'b000, limits.perp_limit_sq};
   assign perp_ok  = {4'd0, s5_sq_ff} <= perp_rhs;

   assign out_valid      = s5_valid_ff;
   assign out_word.match = s5_nok_ff & perp_ok;
   assign out_word.frame = s5_frame_ff;
   assign out_word.last  = s5_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_dx_ff    <= s1_dx_in;
      s1_dy_ff    <= s1_dy_in;
      s1_nx_ff    <= in_item.normal_x;
      s1_ny_ff    <= in_item.normal_y;
      s1_frame_ff <= in_item.frame_index;
      s1_last_ff  <= in_item.last;

      s2_pxn_ff   <= s2_pxn_in;
      s2_pyn_ff   <= s2_pyn_in;
      s2_sxx_ff   <= s2_sxx_in;
      s2_syy_ff   <= s2_syy_in;
      s2_frame_ff <= s1_frame_ff;
      s2_last_ff  <= s1_last_ff;

      s3_dn_ff    <= s3_dn_in;
      s3_sq_ff    <= s3_sq_in;
      s3_frame_ff <= s2_frame_ff;
      s3_last_ff  <= s2_last_ff;

      s4_adn_ff   <= s4_adn_in;
      s4_sq_ff    <= s3_sq_ff;
      s4_frame_ff <= s3_frame_ff;
      s4_last_ff  <= s3_last_ff;

      s5_dsq_ff   <= s5_dsq_in;
      s5_nok_ff   <= s5_nok_in;
      s5_sq_ff    <= s4_sq_ff;
      s5_frame_ff <= s4_frame_ff;
      s5_last_ff  <= s4_last_ff;
   end

endmodule

// ===== hdl/tcor_queue.sv =====
// Short queue of classified frames between the front end and the back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcor_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  tcor_pkg::tcor_word_type push_word,
   input  logic                    pop,
   output logic                    empty,
   output tcor_pkg::tcor_word_type head_word
);

   tcor_pkg::tcor_word_type  mem_ff [tcor_pkg::QUEUE_DEPTH];
   tcor_pkg::tcor_ptr_type   wr_ptr_ff, wr_ptr_in;
   tcor_pkg::tcor_ptr_type   rd_ptr_ff, rd_ptr_in;
   tcor_pkg::tcor_count_type count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign head_word = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tcor_pkg::QUEUE_LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tcor_pkg::QUEUE_LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   // The input credit count must keep the queue from ever overflowing.
   `ASSERT_NEVER(a_queue_no_overflow, clock, reset, push && (count_ff == tcor_pkg::QUEUE_FULL_COUNT))
   `ASSERT_NEVER(a_queue_no_underflow, clock, reset, pop && (count_ff == '0))

endmodule

// ===== hdl/tcor_back.sv =====
// Back end: current and best run tracking and the result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcor_back #(
   parameter int FRAME_LIMIT = tcor_pkg::FRAME_LIMIT_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_empty,
   input  tcor_pkg::tcor_word_type head_word,
   output logic                    take,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [12:0]             rsp_run_length,
   output logic [11:0]             rsp_run_begin,
   output logic [11:0]             rsp_run_end
);

   localparam int LEN_W = $clog2(FRAME_LIMIT + 1);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(FRAME_LIMIT);
   localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);

   logic [LEN_W-1:0] cur_len_ff, cur_len_in;
   logic [11:0]      cur_beg_ff, cur_beg_in;
   logic [11:0]      cur_end_ff, cur_end_in;
   logic [LEN_W-1:0] best_len_ff, best_len_in;
   logic [11:0]      best_beg_ff, best_beg_in;
   logic [11:0]      best_end_ff, best_end_in;
   logic             out_valid_ff, out_valid_in;
   logic [12:0]      out_len_ff, out_len_in;
   logic [11:0]      out_beg_ff, out_beg_in;
   logic [11:0]      out_end_ff, out_end_in;

   // Run state after the head frame, and the best run once it is closed.
   logic [LEN_W-1:0] c_len, b_len, f_len;
   logic [11:0]      c_beg, c_end, b_beg, b_end, f_beg, f_end;
   logic [LEN_W+12:0] f_len_ext;

   // A last frame needs the result register free; other frames always go.
   assign take = !head_empty && (!head_word.last || !out_valid_ff || rsp_pop);

   always_comb begin
      c_len = cur_len_ff;
      c_beg = cur_beg_ff;
      c_end = cur_end_ff;
      b_len = best_len_ff;
      b_beg = best_beg_ff;
      b_end = best_end_ff;
      if (head_word.match) begin
         if (c_len == '0) begin
            c_beg = head_word.frame;
         end
         if (c_len < LEN_LIMIT) begin
            c_len = c_len + 1'b1;
         end
         c_end = head_word.frame;
      end else begin
         if (c_len > b_len) begin
            b_len = c_len;
            b_beg = c_beg;
            b_end = c_end;
         end
         c_len = '0;
      end
      // A later run wins only when strictly longer.
      f_len = b_len;
      f_beg = b_beg;
      f_end = b_end;
      if (c_len > b_len) begin
         f_len = c_len;
         f_beg = c_beg;
         f_end = c_end;
      end
   end

   assign f_len_ext = {{13{1'b0}}, f_len};

   always_comb begin
      cur_len_in   = cur_len_ff;
      cur_beg_in   = cur_beg_ff;
      cur_end_in   = cur_end_ff;
      best_len_in  = best_len_ff;
      best_beg_in  = best_beg_ff;
      best_end_in  = best_end_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_len_in   = out_len_ff;
      out_beg_in   = out_beg_ff;
      out_end_in   = out_end_ff;
      if (take) begin
         if (head_word.last) begin
            cur_len_in   = '0;
            cur_beg_in   = '0;
            cur_end_in   = '0;
            best_len_in  = '0;
            best_beg_in  = '0;
            best_end_in  = '0;
            out_valid_in = 1'b1;
            if (f_len > LEN_ONE) begin
               out_len_in = f_len_ext[12:0];
               out_beg_in = f_beg;
               out_end_in = f_end;
            end else begin
               out_len_in = '0;
               out_beg_in = '0;
               out_end_in = '0;
            end
         end else begin
            cur_len_in  = c_len;
            cur_beg_in  = c_beg;
            cur_end_in  = c_end;
            best_len_in = b_len;
            best_beg_in = b_beg;
            best_end_in = b_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_len_ff   <= '0;
         cur_beg_ff   <= '0;
         cur_end_ff   <= '0;
         best_len_ff  <= '0;
         best_beg_ff  <= '0;
         best_end_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_len_ff   <= cur_len_in;
         cur_beg_ff   <= cur_beg_in;
         cur_end_ff   <= cur_end_in;
         best_len_ff  <= best_len_in;
         best_beg_ff  <= best_beg_in;
         best_end_ff  <= best_end_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_len_ff <= out_len_in;
      out_beg_ff <= out_beg_in;
      out_end_ff <= out_end_in;
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_run_length = out_len_ff;
   assign rsp_run_begin  = out_beg_ff;
   assign rsp_run_end    = out_end_ff;

   `ASSERT_NEVER(a_len_saturates, clock, reset, (cur_len_ff > LEN_LIMIT) || (best_len_ff > LEN_LIMIT))
   `ASSERT_NEXT(a_clear_after_last, clock, reset, take && head_word.last, (cur_len_ff == '0) && (best_len_ff == '0) && out_valid_ff)

endmodule

// ===== hdl/track_contour_overlap_run.sv =====
// Top level of the contour overlap run block: longest run of matching frames.
//
// Usage: each input word carries one overlapping frame of a contour and track
// pair (contour point, unit normal, track point, frame index, last flag). It
// is taken on a rising edge with req_push high and req_full low. A frame
// matches when the distance along the normal and the squared distance across
// it are within the two limits. Only the word marked last yields a result
// word: the longest run of consecutive matching frames (earliest on ties),
// or zeros if it is not longer than one. It sits on the rsp_ ports while
// rsp_empty is low and is taken on an edge with rsp_pop high.
// Throughput is one word per cycle while req_full is low. The last word passes
// through the five distance stages into the queue, and the run tracker loads
// the result register once that word reaches the queue head and the register
// is free. The limits are to be written through the csr_ port only while
// the block is idle; the user must ensure it, as the block does not enforce it.
// Reset clears the pipeline, the queue, the run state and both limits.
// When the receiver stalls, the result holds; later words still flow until
// the next last word reaches the queue head, then the queue fills and
// req_full rises.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module track_contour_overlap_run #(
   parameter int FRAME_LIMIT = tcor_pkg::FRAME_LIMIT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic signed [15:0]                 req_contour_x,
   input  logic signed [15:0]                 req_contour_y,
   input  logic signed [15:0]                 req_normal_x,
   input  logic signed [15:0]                 req_normal_y,
   input  logic signed [15:0]                 req_track_x,
   input  logic signed [15:0]                 req_track_y,
   input  logic        [11:0]                 req_frame_index,
   input  logic                               req_last,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic        [12:0]                 rsp_run_length,
   output logic        [11:0]                 rsp_run_begin,
   output logic        [11:0]                 rsp_run_end,
   input  logic                               csr_write,
   input  logic [tcor_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tcor_pkg::CSR_DATA_W-1:0]    csr_data
);

   // Match limits. Writes to an index outside the list are dropped.
   logic [33:0] perp_limit_sq_ff, perp_limit_sq_in;
   logic [15:0] normal_limit_ff, normal_limit_in;

   // Words in flight: accepted but not yet taken off the queue by the back
   // end. Holding this at or below the queue depth means the front pipeline never
   // has to stall.
   tcor_pkg::tcor_count_type occ_ff, occ_in;

   logic                      req_accept;
   logic                      take;
   logic                      front_valid;
   logic                      queue_empty;
   tcor_pkg::tcor_item_type   item;
   tcor_pkg::tcor_limits_type limits;
   tcor_pkg::tcor_word_type   front_word;
   tcor_pkg::tcor_word_type   head_word;

   assign req_full   = (occ_ff >= tcor_pkg::QUEUE_FULL_COUNT);
   assign req_accept = req_push && !req_full;

   assign item.contour_x   = req_contour_x;
   assign item.contour_y   = req_contour_y;
   assign item.normal_x    = req_normal_x;
   assign item.normal_y    = req_normal_y;
   assign item.track_x     = req_track_x;
   assign item.track_y     = req_track_y;
   assign item.frame_index = req_frame_index;
   assign item.last        = req_last;

   assign limits.perp_limit_sq = perp_limit_sq_ff;
   assign limits.normal_limit  = normal_limit_ff;

   always_comb begin
      perp_limit_sq_in = perp_limit_sq_ff;
      normal_limit_in  = normal_limit_ff;
      if (csr_write) begin
         case (csr_index)
            tcor_pkg::CSR_PERP_LIMIT_SQ: perp_limit_sq_in = csr_data[33:0];
            tcor_pkg::CSR_NORMAL_LIMIT:  normal_limit_in  = csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (req_accept && !take) begin
         occ_in = occ_ff + 1'b1;
      end else if (take && !req_accept) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         perp_limit_sq_ff <= '0;
         normal_limit_ff  <= '0;
         occ_ff           <= '0;
      end else begin
         perp_limit_sq_ff <= perp_limit_sq_in;
         normal_limit_ff  <= normal_limit_in;
         occ_ff           <= occ_in;
      end
   end

   tcor_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_item   (item),
      .limits    (limits),
      .out_valid (front_valid),
      .out_word  (front_word)
   );

   tcor_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_word (front_word),
      .pop       (take),
      .empty     (queue_empty),
      .head_word (head_word)
   );

   tcor_back #(
      .FRAME_LIMIT (FRAME_LIMIT)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_empty     (queue_empty),
      .head_word      (head_word),
      .take           (take),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_run_length (rsp_run_length),
      .rsp_run_begin  (rsp_run_begin),
      .rsp_run_end    (rsp_run_end)
   );

   // The in-flight count can never pass the queue depth, and a word can only
   // leave the queue if it was counted on the way in.
   `ASSERT_NEVER(a_occ_bound, clock, reset, occ_ff > tcor_pkg::QUEUE_FULL_COUNT)
   `ASSERT_NEVER(a_take_counted, clock, reset, take && (occ_ff == '0))

endmodule
